// File: src/tfte_pkg.sv
// ----------------------------------------------------------------------------
// TCP flow table package
// Shared entry type, mode and status codes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package tfte_pkg;

    localparam int COUNT_W     = 13;
    localparam int TIMEOUT_W   = 31;
    localparam int BKT_FIELD_W = 10;
    localparam int IN_DATA_W   = 200;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 152;
    localparam int OUT_USER_W  = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 31'd120;

    localparam logic [2:0] MODE_LOC    = 3'd0;
    localparam logic [2:0] MODE_LOOKUP = 3'd1;
    localparam logic [2:0] MODE_UPDATE = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_SWEEP  = 3'd4;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_UPDATED   = 3'd5;
    localparam logic [2:0] ST_SWEPT     = 3'd6;

    localparam logic [3:0] CONN_CLOSED = 4'd0;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [3:0]  conn_state;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] stamp;
    } t_entry;

endpackage
`default_nettype wire

// File: src/tcp_flow_table_engine_unit.sv
// ----------------------------------------------------------------------------
// TCP flow table engine
// Bidirectional connection tracking table with bucketed ways and idle sweep.
// ----------------------------------------------------------------------------
// The slave channel takes one request beat: the mode in tuser, the endpoint
// pair, update values and the current time in tdata. The master channel
// returns exactly one result beat per request, status in tuser.
// A request is canonically ordered, then hashed by a shift-add-xor unit
// (mixing, plus quotient, remainder and correcting steps of a reciprocal
// remainder when the bucket count is not a power of two). The ways of the
// bucket are then read one by one from the table, each in a read state and
// a check state; the apply state performs the write and the finish state
// loads the output. A new request is taken only once the previous result is
// loaded into the output register. A sweep reads and checks every slot in
// turn before its result is loaded. After reset a clearing pass invalidates
// every slot; s_axis_tready stays low until it ends. The idle timeout
// register is written through i_cfg_we and i_cfg_wdata; the user must write
// it only between requests, as the block itself does not enforce this.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver holds the engine only once a second result is
// ready.
// ----------------------------------------------------------------------------
`default_nettype none
module tcp_flow_table_engine_unit #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tfte_pkg::TIMEOUT_W-1:0]    i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // addr_a, addr_b, port_a, port_b, next_conn_state, seq_number,
    // ack_number, now_seconds, zero fill
    input  wire logic [tfte_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode
    input  wire logic [tfte_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // bucket_index, key_swapped, flow_conn_state, flow_seq, flow_ack,
    // flow_stamp, total_count, active_count, removed_count, zero fill
    output logic [tfte_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // status
    output logic [tfte_pkg::OUT_USER_W-1:0]        m_axis_tuser
);
    import tfte_pkg::*;

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int WAY_W  = $clog2(WAYS + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK, S_APPLY,
        S_SWEEP_RD, S_SWEEP_CHK, S_FINISH
    } t_state;

    t_state               r_state;
    logic [2:0]           r_mode;
    logic [31:0]          r_a0, r_a1;
    logic [15:0]          r_p0, r_p1;
    logic                 r_swapped;
    logic [3:0]           r_nst;
    logic [31:0]          r_seq, r_ack, r_now;
    logic [BKT_W-1:0]     r_bucket;
    logic [WAY_W-1:0]     r_way;
    logic                 r_found, r_have_free;
    logic [SLOT_W-1:0]    r_hit, r_free, r_slot;
    t_entry               r_hit_e;
    logic [COUNT_W-1:0]   r_total, r_active, r_removed;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [2:0]           r_res_status;
    logic [3:0]           r_res_st;
    logic [31:0]          r_res_seq, r_res_ack, r_res_stamp;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [31:0]          w_in_a, w_in_b;
    logic [15:0]          w_in_pa, w_in_pb;
    logic                 w_swap, w_accept, w_hash_start, w_hash_done;
    logic [BKT_W-1:0]     w_hash_bucket;
    logic [SLOT_W-1:0]    w_probe_addr, w_rd_addr, w_wr_addr;
    logic                 w_we, w_match, w_expire, w_res_ok;
    t_entry               w_rd, w_new, w_wr_data;
    logic [32:0]          w_diff;
    logic [COUNT_W-1:0]   n_total, n_active;
    logic [2:0]           n_status;
    logic [31:0]          w_bkt_ext;

    assign w_in_a   = s_axis_tdata[31:0];
    assign w_in_b   = s_axis_tdata[63:32];
    assign w_in_pa  = s_axis_tdata[79:64];
    assign w_in_pb  = s_axis_tdata[95:80];
    assign w_swap   = (w_in_a > w_in_b) || ((w_in_a == w_in_b) && (w_in_pa > w_in_pb));
    assign s_axis_tready = r_state == S_IDLE;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_hash_start = w_accept && (s_axis_tuser != MODE_SWEEP);

    tfte_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hash_start),
        .i_a0     (w_swap ? w_in_b : w_in_a),
        .i_a1     (w_swap ? w_in_a : w_in_b),
        .i_p0     (w_swap ? w_in_pb : w_in_pa),
        .i_p1     (w_swap ? w_in_pa : w_in_pb),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bucket)
    );

    tfte_table #(.SLOTS(SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd)
    );

    assign w_probe_addr = SLOT_W'(r_bucket) * SLOT_W'(WAYS) + SLOT_W'(r_way);
    assign w_rd_addr    = (r_state == S_SWEEP_RD) ? r_slot : w_probe_addr;
    assign w_match = w_rd.valid && (w_rd.addrs == {r_a0, r_a1})
                     && (w_rd.ports == {r_p0, r_p1});
    assign w_diff   = {1'b0, r_now} - {1'b0, w_rd.stamp};
    assign w_expire = w_rd.valid && (w_rd.stamp != 32'd0) && !w_diff[32]
                      && (w_diff[31:0] > {1'b0, r_timeout});
    assign w_res_ok = r_found || ((r_mode == MODE_LOC) && r_have_free);
    assign w_bkt_ext = 32'(r_bucket);

    always_comb begin
        w_new     = r_hit_e;
        w_we      = 1'b0;
        w_wr_addr = r_hit;
        n_total   = r_total;
        n_active  = r_active;
        n_status  = r_found ? ST_FOUND : ST_NOT_FOUND;
        case (r_mode)
            MODE_LOC: begin
                if (r_found) begin
                    w_new.stamp = r_now;
                end else if (r_have_free) begin
                    w_new     = '{1'b1, {r_a0, r_a1}, {r_p0, r_p1}, CONN_CLOSED,
                                  32'd0, 32'd0, r_now};
                    w_wr_addr = r_free;
                    n_total   = r_total + COUNT_W'(1);
                    n_status  = ST_CREATED;
                end else begin
                    n_status  = ST_FULL;
                end
                w_we = r_found || r_have_free;
            end
            MODE_UPDATE: begin
                if (r_found) begin
                    w_new.conn_state = r_nst;
                    w_new.seq   = r_seq;
                    w_new.ack   = r_ack;
                    w_new.stamp = r_now;
                    n_active = r_active
                        - COUNT_W'((r_hit_e.conn_state != CONN_CLOSED) && (r_active != '0))
                        + COUNT_W'(r_nst != CONN_CLOSED);
                    n_status = ST_UPDATED;
                end
                w_we = r_found;
            end
            MODE_DELETE: begin
                if (r_found) begin
                    w_new.valid = 1'b0;
                    n_total  = r_total - COUNT_W'(r_total != '0);
                    n_active = r_active
                        - COUNT_W'((r_hit_e.conn_state != CONN_CLOSED) && (r_active != '0));
                    n_status = ST_DELETED;
                end
                w_we = r_found;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase

        w_wr_data = w_new;
        if (r_state == S_CLEAR) begin
            w_we      = 1'b1;
            w_wr_addr = r_slot;
            w_wr_data = '0;
        end else if (r_state == S_SWEEP_CHK) begin
            w_we            = w_expire;
            w_wr_addr       = r_slot;
            w_wr_data       = w_rd;
            w_wr_data.valid = 1'b0;
            n_total  = r_total - COUNT_W'(r_total != '0);
            n_active = r_active
                - COUNT_W'((w_rd.conn_state != CONN_CLOSED) && (r_active != '0));
        end else if (r_state != S_APPLY) begin
            w_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_total     <= '0;
            r_active    <= '0;
            r_timeout   <= TIMEOUT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_slot <= r_slot + SLOT_W'(1);
                    if (r_slot == SLOT_W'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode    <= s_axis_tuser;
                        r_a0      <= w_swap ? w_in_b : w_in_a;
                        r_a1      <= w_swap ? w_in_a : w_in_b;
                        r_p0      <= w_swap ? w_in_pb : w_in_pa;
                        r_p1      <= w_swap ? w_in_pa : w_in_pb;
                        r_swapped <= w_swap && (s_axis_tuser != MODE_SWEEP);
                        r_nst     <= s_axis_tdata[99:96];
                        r_seq     <= s_axis_tdata[131:100];
                        r_ack     <= s_axis_tdata[163:132];
                        r_now     <= s_axis_tdata[195:164];
                        r_removed <= '0;
                        r_slot    <= '0;
                        if (s_axis_tuser == MODE_SWEEP) begin
                            r_bucket  <= '0;
                            r_state   <= S_SWEEP_RD;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_bucket    <= w_hash_bucket;
                        r_way       <= '0;
                        r_found     <= 1'b0;
                        r_have_free <= 1'b0;
                        r_state     <= S_PROBE_RD;
                    end
                end
                S_PROBE_RD: begin
                    r_state <= S_PROBE_CHK;
                end
                S_PROBE_CHK: begin
                    if (w_rd.valid) begin
                        if (!r_found && w_match) begin
                            r_found <= 1'b1;
                            r_hit   <= w_probe_addr;
                            r_hit_e <= w_rd;
                        end
                    end else if (!r_have_free) begin
                        r_have_free <= 1'b1;
                        r_free      <= w_probe_addr;
                    end
                    if (r_way == WAY_W'(WAYS - 1)) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_way   <= r_way + WAY_W'(1);
                        r_state <= S_PROBE_RD;
                    end
                end
                S_APPLY: begin
                    r_total      <= n_total;
                    r_active     <= n_active;
                    r_res_status <= n_status;
                    r_res_st     <= w_res_ok ? w_new.conn_state : CONN_CLOSED;
                    r_res_seq    <= w_res_ok ? w_new.seq : 32'd0;
                    r_res_ack    <= w_res_ok ? w_new.ack : 32'd0;
                    r_res_stamp  <= w_res_ok ? w_new.stamp : 32'd0;
                    r_state      <= S_FINISH;
                end
                S_SWEEP_RD: begin
                    r_state <= S_SWEEP_CHK;
                end
                S_SWEEP_CHK: begin
                    if (w_expire) begin
                        r_total   <= n_total;
                        r_active  <= n_active;
                        r_removed <= r_removed + COUNT_W'(1);
                    end
                    if (r_slot == SLOT_W'(SLOTS - 1)) begin
                        r_res_status <= ST_SWEPT;
                        r_res_st     <= CONN_CLOSED;
                        r_res_seq    <= 32'd0;
                        r_res_ack    <= 32'd0;
                        r_res_stamp  <= 32'd0;
                        r_state      <= S_FINISH;
                    end else begin
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= S_SWEEP_RD;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_res_status;
                        r_out_data  <= {2'b00, r_removed, r_active, r_total,
                                        r_res_stamp, r_res_ack, r_res_seq, r_res_st,
                                        r_swapped, w_bkt_ext[BKT_FIELD_W-1:0]};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
`default_nettype wire

// File: src/tfte_hash.sv
// ----------------------------------------------------------------------------
// TCP flow table hash unit
// Shift-add-xor hash over four key words, one word per cycle, then a
// remainder by the bucket count through a reciprocal multiply and one
// correcting subtract unless the bucket count is a power of two.
// ----------------------------------------------------------------------------
`default_nettype none
module tfte_hash #(
    parameter int BUCKETS = 1024,
    localparam int BKT_W  = $clog2(BUCKETS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_a0,
    input  wire logic [31:0]      i_a1,
    input  wire logic [15:0]      i_p0,
    input  wire logic [15:0]      i_p1,
    output logic                  o_done,
    output logic [BKT_W-1:0]      o_bucket
);
    import tfte_pkg::*;

    localparam bit          IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam longint      RECIP   = (longint'(1) << 32) / longint'(BUCKETS);
    localparam logic [31:0] RECIP_W = 32'(RECIP);
    localparam logic [31:0] BKT_VAL = 32'(BUCKETS);

    typedef enum logic [2:0] {H_IDLE, H_MIX, H_QUOT, H_REM, H_FIX, H_DONE} t_hstate;

    t_hstate           r_state;
    logic [31:0]       r_h;
    logic [31:0]       r_word [4];
    logic [1:0]        r_cnt;
    logic [31:0]       r_q;
    logic [31:0]       r_rem;
    logic [31:0]       n_mix;
    logic [63:0]       n_prod;

    assign n_mix   = ((r_h << 5) + r_h) ^ r_word[0];
    assign n_prod  = 64'(r_h) * 64'(RECIP_W);
    assign o_done  = r_state == H_DONE;
    assign o_bucket = IS_POW2 ? r_h[BKT_W-1:0] : r_rem[BKT_W-1:0];

    // The quotient estimate is at most one below the true quotient, so a
    // single compare and subtract finishes the remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_h       <= 32'd5381;
                        r_word[0] <= i_a0;
                        r_word[1] <= i_a1;
                        r_word[2] <= {16'd0, i_p0};
                        r_word[3] <= {16'd0, i_p1};
                        r_cnt     <= '0;
                        r_state   <= H_MIX;
                    end
                end
                H_MIX: begin
                    r_h       <= n_mix;
                    r_word[0] <= r_word[1];
                    r_word[1] <= r_word[2];
                    r_word[2] <= r_word[3];
                    r_cnt     <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= IS_POW2 ? H_DONE : H_QUOT;
                    end
                end
                H_QUOT: begin
                    r_q     <= n_prod[63:32];
                    r_state <= H_REM;
                end
                H_REM: begin
                    r_rem   <= r_h - r_q * BKT_VAL;
                    r_state <= H_FIX;
                end
                H_FIX: begin
                    r_rem   <= (r_rem >= BKT_VAL) ? r_rem - BKT_VAL : r_rem;
                    r_state <= H_DONE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/tfte_table.sv
// ----------------------------------------------------------------------------
// TCP flow table storage
// One write port and one registered read port over all entry slots.
// ----------------------------------------------------------------------------
`default_nettype none
module tfte_table #(
    parameter int SLOTS  = 4096,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [SLOT_W-1:0] i_waddr,
    input  wire tfte_pkg::t_entry  i_wdata,
    input  wire logic [SLOT_W-1:0] i_raddr,
    output tfte_pkg::t_entry       o_rdata
);
    import tfte_pkg::*;

    t_entry r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: sim/tb_tcp_flow_table_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP flow table engine testbench
// Drives request beats with random gaps and result stalls. A scoreboard keeps
// its own copy of the flow table and the idle timeout, predicts one result per
// request and compares every field of each result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_tcp_flow_table_engine_unit;
    import tfte_pkg::*;

    localparam int NBKT  = 1024;
    localparam int NWAY  = 4;
    localparam int NSLOT = NBKT * NWAY;
    localparam longint LIMIT = 3_000_000;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  bucket;
        logic        swapped;
        logic [3:0]  conn_state;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] stamp;
        logic [12:0] total;
        logic [12:0] active;
        logic [12:0] removed;
    } t_flow_result;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [15:0] port_a;
        logic [15:0] port_b;
        logic [3:0]  next_state;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] now;
    } t_flow_request;

    class flow_scoreboard;
        t_entry         table_q[NSLOT];
        int unsigned    valid_count;
        int unsigned    open_count;
        logic [30:0]    idle_timeout;
        t_flow_result   pending[$];
        int             mismatches;

        function new();
            foreach (table_q[i]) table_q[i] = '0;
            valid_count = 0;
            open_count = 0;
            idle_timeout = TIMEOUT_RST;
            mismatches = 0;
        endfunction

        function void drop(int s);
            table_q[s].valid = 1'b0;
            if (valid_count > 0) valid_count--;
            if (table_q[s].conn_state != CONN_CLOSED && open_count > 0) open_count--;
        endfunction

        function void note_request(t_flow_request r);
            t_flow_result res;
            logic [31:0] a0, a1, h, t32;
            logic [15:0] p0, p1, t16;
            int base, hit, free_slot;
            bit found, have_free;
            res = '0;
            res.status = ST_NOT_FOUND;
            if (r.mode == MODE_SWEEP) begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (table_q[s].valid && table_q[s].stamp != 0 &&
                        (longint'(r.now) - longint'(table_q[s].stamp)) >
                        longint'(idle_timeout)) begin
                        drop(s);
                        res.removed++;
                    end
                end
                res.status = ST_SWEPT;
            end else begin
                a0 = r.addr_a; a1 = r.addr_b; p0 = r.port_a; p1 = r.port_b;
                if (a0 > a1 || (a0 == a1 && p0 > p1)) begin
                    t32 = a0; a0 = a1; a1 = t32;
                    t16 = p0; p0 = p1; p1 = t16;
                    res.swapped = 1'b1;
                end
                h = 32'd5381;
                h = ((h << 5) + h) ^ a0;
                h = ((h << 5) + h) ^ a1;
                h = ((h << 5) + h) ^ {16'd0, p0};
                h = ((h << 5) + h) ^ {16'd0, p1};
                res.bucket = 10'(h % NBKT);
                base = int'(res.bucket) * NWAY;
                found = 0; have_free = 0; hit = 0; free_slot = 0;
                for (int w = 0; w < NWAY; w++) begin
                    if (table_q[base+w].valid) begin
                        if (!found && table_q[base+w].addrs == {a0, a1} &&
                            table_q[base+w].ports == {p0, p1}) begin
                            found = 1; hit = base + w;
                        end
                    end else if (!have_free) begin
                        have_free = 1; free_slot = base + w;
                    end
                end
                if (r.mode == MODE_LOC) begin
                    if (found) begin
                        table_q[hit].stamp = r.now;
                        res.status = ST_FOUND;
                    end else if (have_free) begin
                        hit = free_slot;
                        table_q[hit] = '{1'b1, {a0, a1}, {p0, p1}, CONN_CLOSED, 32'd0,
                                         32'd0, r.now};
                        valid_count++;
                        found = 1;
                        res.status = ST_CREATED;
                    end else begin
                        res.status = ST_FULL;
                    end
                end else if (r.mode == MODE_UPDATE) begin
                    if (found) begin
                        if (table_q[hit].conn_state != CONN_CLOSED && open_count > 0)
                            open_count--;
                        table_q[hit].conn_state = r.next_state;
                        if (r.next_state != CONN_CLOSED) open_count++;
                        table_q[hit].seq = r.seq;
                        table_q[hit].ack = r.ack;
                        table_q[hit].stamp = r.now;
                        res.status = ST_UPDATED;
                    end
                end else if (r.mode == MODE_DELETE) begin
                    if (found) begin
                        drop(hit);
                        res.status = ST_DELETED;
                    end
                end else if (found) begin
                    res.status = ST_FOUND;
                end
                if (found) begin
                    res.conn_state = table_q[hit].conn_state;
                    res.seq = table_q[hit].seq;
                    res.ack = table_q[hit].ack;
                    res.stamp = table_q[hit].stamp;
                end
            end
            res.total = valid_count[12:0];
            res.active = open_count[12:0];
            pending.push_back(res);
        endfunction

        function void check_result(t_flow_result got);
            t_flow_result exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Result beat with no request pending: %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch at %0t", $realtime);
                    $display("  expected %p", exp_r);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [TIMEOUT_W-1:0]  i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    flow_scoreboard board;
    longint         cycle_count = 0;
    bit             sending_done = 0;
    t_flow_request  known_flows[$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    tcp_flow_table_engine_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always @(posedge i_clk) begin
        t_flow_result got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status     = m_axis_tuser;
            got.bucket     = m_axis_tdata[9:0];
            got.swapped    = m_axis_tdata[10];
            got.conn_state = m_axis_tdata[14:11];
            got.seq        = m_axis_tdata[46:15];
            got.ack        = m_axis_tdata[78:47];
            got.stamp      = m_axis_tdata[110:79];
            got.total      = m_axis_tdata[123:111];
            got.active     = m_axis_tdata[136:124];
            got.removed    = m_axis_tdata[149:137];
            board.check_result(got);
        end
    end

    // Receiver: random stalls before each beat, with calm stretches.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_request(t_flow_request r);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {4'd0, r.now, r.ack, r.seq, r.next_state, r.port_b, r.port_a,
                         r.addr_b, r.addr_a};
        s_axis_tuser <= r.mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [30:0] value);
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.idle_timeout = value;
    endtask

    function automatic t_flow_request random_request(int unsigned now_base);
        t_flow_request r;
        r.addr_a = $urandom(); r.addr_b = $urandom();
        r.port_a = 16'($urandom()); r.port_b = 16'($urandom());
        r.next_state = 4'($urandom()); r.seq = $urandom(); r.ack = $urandom();
        r.now = now_base + $urandom_range(0, 300);
        r.mode = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 7 && known_flows.size() > 0) begin
            t_flow_request k;
            k = known_flows[$urandom_range(0, known_flows.size() - 1)];
            if ($urandom_range(0, 1)) begin
                r.addr_a = k.addr_b; r.addr_b = k.addr_a;
                r.port_a = k.port_b; r.port_b = k.port_a;
            end else begin
                r.addr_a = k.addr_a; r.addr_b = k.addr_b;
                r.port_a = k.port_a; r.port_b = k.port_b;
            end
            r.mode = 3'($urandom_range(0, 3));
        end
        if (r.mode == MODE_SWEEP && $urandom_range(0, 2) != 0) r.mode = MODE_LOC;
        if ($urandom_range(0, 15) == 0) r.now = $urandom();
        return r;
    endfunction

    initial begin
        t_flow_request r;
        int unsigned clock_s;
        board = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, every mode, swaps, full bucket, sweeps.
        r = '{MODE_LOC, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 4'hF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'd100};
        send_request(r);
        r.mode = MODE_LOOKUP; r.now = 32'd500; send_request(r);
        r.mode = MODE_UPDATE; send_request(r);
        r.mode = MODE_LOC; r.now = 32'hFFFF_FFFF; send_request(r);
        r.mode = 3'd5; send_request(r);
        r.mode = 3'd7; send_request(r);
        r = '{MODE_LOC, 32'h0A00_0001, 32'h0A00_0001, 16'd80, 16'd80, 4'd0, 32'd0, 32'd0,
              32'd0};
        send_request(r);
        r.mode = MODE_UPDATE; r.next_state = 4'd4; r.seq = 32'd1; r.ack = 32'd2;
        send_request(r);
        r.mode = MODE_LOC; r.port_a = 16'd9000; r.now = 32'd10; send_request(r);
        r.mode = MODE_LOOKUP; r.port_a = 16'd80; r.port_b = 16'd9000; send_request(r);
        // Five flows that differ only in the top bits of addr_b share a bucket.
        for (int i = 0; i < 5; i++) begin
            r = '{MODE_LOC, 32'd1, 32'h2000_0000 + (i << 22) * 32, 16'd1, 16'd2, 4'd0,
                  32'd0, 32'd0, 32'd50};
            send_request(r);
        end
        r.mode = MODE_DELETE; send_request(r);
        r.addr_b = 32'h2000_0000; send_request(r);
        send_request(r);
        r.mode = MODE_UPDATE; send_request(r);
        r.mode = MODE_SWEEP; r.now = 32'd0; send_request(r);
        r.now = 32'd171; send_request(r);
        r.now = 32'h8000_0000; send_request(r);
        r = '{MODE_LOC, 32'h1234_5678, 32'h1234_5678, 16'd7, 16'd7, 4'd0, 32'd0,
              32'd0, 32'd0};
        send_request(r);
        r.mode = MODE_DELETE; send_request(r);

        write_timeout(31'd0);
        r.mode = MODE_SWEEP; r.now = 32'hFFFF_FFFF; send_request(r);
        write_timeout(31'h7FFF_FFFF);
        r.now = 32'hFFFF_FFFF; send_request(r);

        clock_s = 1000;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_timeout(31'd120);
                1: write_timeout(31'd30);
                2: write_timeout(31'd1);
                default: write_timeout(31'h7FFF_FFFF);
            endcase
            for (int n = 0; n < 210; n++) begin
                r = random_request(clock_s);
                if (r.mode == MODE_LOC && known_flows.size() < 200) known_flows.push_back(r);
                send_request(r);
                clock_s += $urandom_range(0, 4);
            end
            r.mode = MODE_SWEEP; r.now = clock_s + 100; send_request(r);
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() != 0 && cycle_count < LIMIT) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.pending.size() == 0 && board.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// File: tcp_flow_table_engine_unit.f
src/tfte_pkg.sv
src/tfte_hash.sv
src/tfte_table.sv
src/tcp_flow_table_engine_unit.sv
sim/tb_tcp_flow_table_engine_unit.sv
